/* sv/aes_pkg.sv */
package aes_pkg;

    localparam int Rounds = 10;
    localparam int WordW  = 64;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_IV_HIGH  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_IV_LOW   = 2'd3;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

/* sv/aes128_cbc_cipher_unit.sv */
// aes-128 cbc cipher, one 128-bit word per item. an accepted word first reruns the
// key expansion into the round key memory (one round key per cycle, which always
// sees the current key registers), then runs the cipher from that memory through a
// registered read port: the first key read, the initial key add, ten rounds, and the
// load of the output register. a new word is taken only after the last one has left
// the core for the output register. only one word is in flight, since cbc chaining makes
// each word depend on the one before. the result sits in an output register and the
// next word is taken while it waits; that word then holds in the core, with the input
// stalled, until the register is free. chain value resets to zero; a word marked first
// uses the iv in its place.
module aes128_cbc_cipher_unit #(
    parameter int ROUNDS = aes_pkg::Rounds
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic        i_first,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [aes_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int RkW = $clog2(ROUNDS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_KEY  = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state       r_fsm;
    logic [127:0] r_key, r_iv, r_chain, r_st, r_in;
    logic         r_dec, r_first;
    logic [RkW-1:0] r_rnd;
    logic         r_first_rd;
    logic         r_oval;
    logic [127:0] r_out;

    // round key memory, registered read
    logic [127:0] r_rkmem [ROUNDS+1];
    logic [127:0] r_rk;
    logic [RkW-1:0] rd_addr;

    logic           ks_we, ks_busy, ks_start;
    logic [RkW-1:0] ks_waddr;
    logic [127:0]   ks_wdata, rnd_out, chain_use;
    logic           accept;
    logic           out_load;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_fsm != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign ks_start = accept;
    // finished word moves to the output register once it is free
    assign out_load = (r_fsm == S_DONE) && (!r_oval || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                aes_pkg::CFG_KEY_HIGH: r_key[127:64] <= i_cfg_data;
                aes_pkg::CFG_KEY_LOW:  r_key[63:0]   <= i_cfg_data;
                aes_pkg::CFG_IV_HIGH:  r_iv[127:64]  <= i_cfg_data;
                aes_pkg::CFG_IV_LOW:   r_iv[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_key_sched #(.ROUNDS(ROUNDS)) u_ks (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(ks_start), .i_key(r_key),
        .o_we(ks_we), .o_waddr(ks_waddr), .o_wdata(ks_wdata), .o_busy(ks_busy)
    );

    // next round key address: first read is key 0 (enc) or key ROUNDS (dec)
    always_comb begin
        if (r_fsm == S_KEY) rd_addr = r_dec ? RkW'(ROUNDS) : '0;
        else rd_addr = r_dec ? r_rnd - RkW'(1) : r_rnd + RkW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (ks_we) r_rkmem[ks_waddr] <= ks_wdata;
        r_rk <= r_rkmem[rd_addr];
    end

    assign chain_use = r_first ? r_iv : r_chain;

    aes_round u_rnd (
        .i_dec(r_dec),
        .i_last(r_dec ? (r_rnd == '0) : (r_rnd == RkW'(ROUNDS))),
        .i_state(r_st), .i_rkey(r_rk), .o_state(rnd_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_oval  <= 1'b0;
            r_chain <= '0;
            r_first <= 1'b0;
        end else begin
            if (out_load) r_oval <= 1'b1;
            else if (!i_stall) r_oval <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (accept) begin
                        r_fsm   <= S_KEY;
                        r_dec   <= i_func == aes_pkg::FUNC_DEC;
                        r_first <= i_first;
                        r_in    <= {i_block_high, i_block_low};
                    end
                end
                S_KEY: begin
                    // key memory holds every round key once the schedule ends
                    if (!ks_busy) begin
                        r_fsm      <= S_RUN;
                        r_first_rd <= 1'b1;
                        r_rnd      <= r_dec ? RkW'(ROUNDS) : '0;
                        r_st       <= r_dec ? r_in : (r_in ^ chain_use);
                    end
                end
                S_RUN: begin
                    r_first_rd <= 1'b0;
                    if (r_first_rd) begin
                        // initial key add
                        r_st  <= r_st ^ r_rk;
                        r_rnd <= r_dec ? r_rnd - RkW'(1) : r_rnd + RkW'(1);
                    end else begin
                        r_st <= rnd_out;
                        if (r_dec ? (r_rnd == '0) : (r_rnd == RkW'(ROUNDS))) begin
                            r_fsm <= S_DONE;
                        end else begin
                            r_rnd <= r_dec ? r_rnd - RkW'(1) : r_rnd + RkW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_fsm   <= S_IDLE;
                        r_out   <= r_dec ? (r_st ^ chain_use) : r_st;
                        r_chain <= r_dec ? r_in : r_st;
                        r_first <= 1'b0;
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_oval;
    assign o_result_high = r_out[127:64];
    assign o_result_low  = r_out[63:0];

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != S_IDLE) |-> !accept) else $error("accept while busy");
    a_run_after_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_RUN) |-> !ks_busy) else $error("rounds overlap key expansion");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oval && i_stall) |=> (r_oval && $stable(r_out))) else $error("result lost");
    a_key_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ks_busy) else $error("key expansion not started");
`endif
endmodule

/* sv/aes_key_sched.sv */
// key expansion, one round key per cycle, written into the round key memory
module aes_key_sched #(
    parameter int ROUNDS = aes_pkg::Rounds,
    localparam int RkW = $clog2(ROUNDS + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [127:0]   i_key,
    output logic           o_we,
    output logic [RkW-1:0] o_waddr,
    output logic [127:0]   o_wdata,
    output logic           o_busy
);
    logic [127:0]   r_key;
    logic [7:0]     r_rc;
    logic [RkW-1:0] r_idx;
    logic           r_busy;
    logic [127:0]   n_key;
    logic [31:0]    w0, w1, w2, w3, t;

    always_comb begin
        t  = {aes_pkg::sbox(r_key[23:16]), aes_pkg::sbox(r_key[15:8]),
              aes_pkg::sbox(r_key[7:0]), aes_pkg::sbox(r_key[31:24])} ^ {r_rc, 24'h0};
        w0 = r_key[127:96] ^ t;
        w1 = r_key[95:64] ^ w0;
        w2 = r_key[63:32] ^ w1;
        w3 = r_key[31:0] ^ w2;
        n_key = {w0, w1, w2, w3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_key  <= i_key;
            r_rc   <= 8'h01;
        end else if (r_busy) begin
            r_key <= n_key;
            r_rc  <= aes_pkg::xt(r_rc);
            r_idx <= r_idx + RkW'(1);
            if (r_idx == RkW'(ROUNDS)) r_busy <= 1'b0;
        end
    end

    assign o_we    = r_busy;
    assign o_waddr = r_idx;
    assign o_wdata = r_key;
    assign o_busy  = r_busy;
endmodule

/* sv/aes_round.sv */
// one forward or inverse round, pure logic between the state register and memory data
module aes_round (
    input  logic         i_dec,
    input  logic         i_last,
    input  logic [127:0] i_state,
    input  logic [127:0] i_rkey,
    output logic [127:0] o_state
);
    logic [7:0] s [16];
    logic [7:0] a [16];
    logic [7:0] m [16];
    logic [7:0] b0, b1, b2, b3, x2, x4, x8;
    int c;

    always_comb begin
        x2 = 8'h00;
        x4 = 8'h00;
        x8 = 8'h00;
        for (int i = 0; i < 16; i++) s[i] = i_state[127-8*i -: 8];
        // shift rows then sub bytes (order commutes)
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
                a[r+4*k] = i_dec ? aes_pkg::inv_sbox(s[r+4*((k-r+4)&3)])
                                 : aes_pkg::sbox(s[r+4*((k+r)&3)]);
            end
        end
        // inverse order: add key, then inv mix
        if (i_dec) begin
            for (int i = 0; i < 16; i++) a[i] = a[i] ^ i_rkey[127-8*i -: 8];
        end
        for (c = 0; c < 4; c++) begin
            b0 = a[4*c]; b1 = a[4*c+1]; b2 = a[4*c+2]; b3 = a[4*c+3];
            if (!i_dec) begin
                m[4*c]   = aes_pkg::xt(b0) ^ aes_pkg::xt(b1) ^ b1 ^ b2 ^ b3;
                m[4*c+1] = b0 ^ aes_pkg::xt(b1) ^ aes_pkg::xt(b2) ^ b2 ^ b3;
                m[4*c+2] = b0 ^ b1 ^ aes_pkg::xt(b2) ^ aes_pkg::xt(b3) ^ b3;
                m[4*c+3] = aes_pkg::xt(b0) ^ b0 ^ b1 ^ b2 ^ aes_pkg::xt(b3);
            end else begin
                // inverse mix as preprocessing times forward mix
                x2 = b0 ^ b2;
                x4 = aes_pkg::xt(aes_pkg::xt(x2));
                x8 = aes_pkg::xt(aes_pkg::xt(b1 ^ b3));
                b0 = b0 ^ x4; b2 = b2 ^ x4; b1 = b1 ^ x8; b3 = b3 ^ x8;
                m[4*c]   = aes_pkg::xt(b0) ^ aes_pkg::xt(b1) ^ b1 ^ b2 ^ b3;
                m[4*c+1] = b0 ^ aes_pkg::xt(b1) ^ aes_pkg::xt(b2) ^ b2 ^ b3;
                m[4*c+2] = b0 ^ b1 ^ aes_pkg::xt(b2) ^ aes_pkg::xt(b3) ^ b3;
                m[4*c+3] = aes_pkg::xt(b0) ^ b0 ^ b1 ^ b2 ^ aes_pkg::xt(b3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (i_last) o_state[127-8*i -: 8] = a[i] ^ (i_dec ? 8'h00 : i_rkey[127-8*i -: 8]);
            else if (i_dec) o_state[127-8*i -: 8] = m[i];
            else o_state[127-8*i -: 8] = m[i] ^ i_rkey[127-8*i -: 8];
        end
    end
endmodule
